// ===== rtl/dprw_pkg.sv =====
package dprw_pkg;

  // Sizes are powers of two: page and offset split by bit position.
  localparam int VPAGES     = 16;
  localparam int FRAMES     = 4;
  localparam int PAGE_WORDS = 8;
  localparam int DATA_WIDTH = 32;

  localparam int VADDR_W = 7;
  localparam int WORD_W  = 32;
  localparam int PG_W    = $clog2(VPAGES);
  localparam int FR_W    = $clog2(FRAMES);
  localparam int OFF_W   = $clog2(PAGE_WORDS);
  localparam int FF_W    = $clog2(FRAMES + 1);
  localparam int CNT_W   = $clog2(PAGE_WORDS + 1);

  typedef logic [PG_W-1:0]              page_t;
  typedef logic [FR_W-1:0]              frame_t;
  typedef logic [OFF_W-1:0]             off_t;
  typedef logic [FF_W-1:0]              fill_t;
  typedef logic [DATA_WIDTH-1:0]        dword_t;
  typedef logic [FRAMES-1:0][FR_W-1:0]  rank_vec_t;

  typedef struct packed {
    logic  lookup;
    logic  set_dirty;
    page_t page;
  } pt_cmd_t;

  typedef struct packed {
    logic   hit;
    logic   victim_dirty;
    frame_t frame;
    page_t  owner;
  } pt_rsp_t;

  localparam dword_t ALL_ONES = '1;

  function automatic page_t page_of(input logic [VADDR_W-1:0] v);
    return page_t'(v >> OFF_W);
  endfunction

  function automatic off_t off_of(input logic [VADDR_W-1:0] v);
    return off_t'(v);
  endfunction

  function automatic dword_t ext_word(input logic signed [WORD_W-1:0] w);
    dword_t r;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      r[i] = (i < WORD_W) ? w[i % WORD_W] : w[WORD_W-1];
    end
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] out_word(input dword_t d);
    logic signed [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = (i < DATA_WIDTH) ? d[i % DATA_WIDTH] : 1'b0;
    end
    return r;
  endfunction

  // Frame f becomes newest; filled frames above its old rank slide down one.
  function automatic rank_vec_t promote(input rank_vec_t r, input frame_t f,
                                        input frame_t old, input frame_t top,
                                        input fill_t cnt);
    rank_vec_t n;
    n = r;
    for (int g = 0; g < FRAMES; g++) begin
      if (fill_t'(g) < cnt && frame_t'(g) != f && r[g] > old) begin
        n[g] = r[g] - 1'b1;
      end
    end
    n[f] = top;
    return n;
  endfunction

  // Lowest rank wins, first frame on a tie.
  function automatic frame_t pick_victim(input rank_vec_t r);
    frame_t best;
    best = '0;
    for (int g = 1; g < FRAMES; g++) begin
      if (r[g] < r[best]) begin
        best = frame_t'(g);
      end
    end
    return best;
  endfunction

endpackage

// ===== rtl/dprw_req_if.sv =====
interface dprw_req_if;
  import dprw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [VADDR_W-1:0]       vaddr;
  logic signed [WORD_W-1:0] wdata;

  modport source (output valid, req_type, vaddr, wdata, input ready);
  modport sink   (input valid, req_type, vaddr, wdata, output ready);
endinterface

// ===== rtl/dprw_rsp_if.sv =====
interface dprw_rsp_if;
  import dprw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] rdata;
  logic                     page_fault;
  logic                     dirty_evicted;

  modport source (output valid, rdata, page_fault, dirty_evicted, input ready);
  modport sink   (input valid, rdata, page_fault, dirty_evicted, output ready);
endinterface

// ===== rtl/dprw_cfg_if.sv =====
interface dprw_cfg_if;
  logic valid;
  logic ready;
  logic replacement_mode;

  modport source (output valid, replacement_mode, input ready);
  modport sink   (input valid, replacement_mode, output ready);
endinterface

// ===== rtl/demand_paging_with_replacement_unit.sv =====
// Channel  Dir  Beat payload                            Accepted when
// -------  ---  --------------------------------------  -------------------
// in_i     in   req_type, vaddr, wdata                  valid & ready
// out_o    out  rdata, page_fault, dirty_evicted        valid & ready
// cfg_i    in   replacement_mode                        valid & ready
//
// One request at a time. A hit steps through accept, lookup, access and
// result. A miss adds a page load, and a dirty victim a copy-back ahead
// of the load. The page copies go through the single read port of each
// memory.
// Reset clears the page table, the rank orders and the backing row marks;
// no clearing pass. A result held on out_o stalls only the final step; the
// next request is still taken while it waits.
module demand_paging_with_replacement_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  dprw_req_if.sink    in_i,
  dprw_rsp_if.source  out_o,
  dprw_cfg_if.sink    cfg_i
);
  import dprw_pkg::*;

  localparam int PA_W = FR_W + OFF_W;
  localparam int BA_W = PG_W + OFF_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_EVICT  = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_ACCESS = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              mode_q;

  // request held for the whole walk
  logic              is_wr_q;
  page_t             page_q;
  off_t              off_q;
  dword_t            wd_q;

  // lookup outcome
  frame_t            frame_q;
  page_t             owner_q;
  logic              miss_q;
  logic              evict_q;

  // backing rows never written back still hold their reset words
  logic [VPAGES-1:0] bk_row_q, bk_row_d;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic signed [WORD_W-1:0] rdata_q;
  logic                     fault_q;
  logic                     dev_q;

  pt_cmd_t pt_cmd;
  pt_rsp_t pt_rsp;

  // memory ports
  logic              ph_we, ph_re, bk_we, bk_re;
  logic [PA_W-1:0]   ph_waddr, ph_raddr;
  logic [BA_W-1:0]   bk_waddr, bk_raddr;
  dword_t            ph_wdata, ph_rdata, bk_rdata;

  logic              cnt_end;
  off_t              cnt_off, cnt_prev;
  logic              in_beat, out_free;

  assign cnt_end  = (cnt_q == CNT_W'(PAGE_WORDS));
  assign cnt_off  = off_t'(cnt_q);
  assign cnt_prev = off_t'(cnt_q - 1'b1);
  assign in_beat  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign pt_cmd.lookup    = (state_q == S_LOOKUP);
  assign pt_cmd.set_dirty = (state_q == S_ACCESS) && is_wr_q;
  assign pt_cmd.page      = page_q;

  dprw_pt u_pt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .cmd_i  (pt_cmd),
    .rsp_o  (pt_rsp)
  );

  // Memory port steering. Copies read word n while writing word n-1.
  always_comb begin
    ph_we    = 1'b0;
    ph_re    = 1'b0;
    bk_we    = 1'b0;
    bk_re    = 1'b0;
    ph_waddr = {frame_q, cnt_prev};
    ph_raddr = {frame_q, cnt_off};
    ph_wdata = bk_row_q[page_q] ? bk_rdata : ALL_ONES;
    bk_waddr = {owner_q, cnt_prev};
    bk_raddr = {page_q, cnt_off};
    unique case (state_q)
      S_EVICT: begin
        ph_re = !cnt_end;
        bk_we = (cnt_q != '0);
      end
      S_LOAD: begin
        bk_re = !cnt_end;
        ph_we = (cnt_q != '0);
      end
      S_ACCESS: begin
        ph_waddr = {frame_q, off_q};
        ph_raddr = {frame_q, off_q};
        ph_wdata = wd_q;
        ph_we    = is_wr_q;
        ph_re    = !is_wr_q;
      end
      default: begin
      end
    endcase
  end

  dprw_ram #(.WIDTH(DATA_WIDTH), .DEPTH(FRAMES * PAGE_WORDS)) u_phys (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (ph_waddr),
    .wdata_i (ph_wdata),
    .re_i    (ph_re),
    .raddr_i (ph_raddr),
    .rdata_o (ph_rdata)
  );

  dprw_ram #(.WIDTH(DATA_WIDTH), .DEPTH(VPAGES * PAGE_WORDS)) u_backing (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (bk_waddr),
    .wdata_i (ph_rdata),
    .re_i    (bk_re),
    .raddr_i (bk_raddr),
    .rdata_o (bk_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bk_row_d    = bk_row_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cnt_d = '0;
        if (pt_rsp.hit) begin
          state_d = S_ACCESS;
        end else if (pt_rsp.victim_dirty) begin
          state_d = S_EVICT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_EVICT: begin
        if (cnt_end) begin
          cnt_d             = '0;
          bk_row_d[owner_q] = 1'b1;
          state_d           = S_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LOAD: begin
        if (cnt_end) begin
          cnt_d   = '0;
          state_d = S_ACCESS;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ACCESS: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      bk_row_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bk_row_q    <= bk_row_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.replacement_mode;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      is_wr_q <= in_i.req_type;
      page_q  <= page_of(in_i.vaddr);
      off_q   <= off_of(in_i.vaddr);
      wd_q    <= ext_word(in_i.wdata);
    end
    if (state_q == S_LOOKUP) begin
      frame_q <= pt_rsp.frame;
      owner_q <= pt_rsp.owner;
      miss_q  <= !pt_rsp.hit;
      evict_q <= pt_rsp.victim_dirty;
    end
    if (state_q == S_DONE && out_free) begin
      rdata_q <= out_word(is_wr_q ? wd_q : ph_rdata);
      fault_q <= miss_q;
      dev_q   <= evict_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.rdata         = rdata_q;
  assign out_o.page_fault    = fault_q;
  assign out_o.dirty_evicted = dev_q;

endmodule

// ===== rtl/dprw_ram.sv =====
module dprw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dprw_pt.sv =====
module dprw_pt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mode_i,
  input  dprw_pkg::pt_cmd_t   cmd_i,
  output dprw_pkg::pt_rsp_t   rsp_o
);
  import dprw_pkg::*;

  logic [VPAGES-1:0] valid_q, valid_d;
  logic [VPAGES-1:0] dirty_q, dirty_d;
  frame_t            pt_frame_q [VPAGES];
  page_t             owner_q    [FRAMES];
  rank_vec_t         load_rank_q, load_rank_d;
  rank_vec_t         use_rank_q, use_rank_d;
  fill_t             filled_q, filled_d;

  logic   hit, full;
  frame_t victim, frame;
  page_t  owner;
  fill_t  filled_inc;

  assign hit        = valid_q[cmd_i.page];
  assign full       = (filled_q == fill_t'(FRAMES));
  assign victim     = pick_victim(mode_i ? use_rank_q : load_rank_q);
  assign owner      = owner_q[victim];
  assign filled_inc = filled_q + 1'b1;

  always_comb begin
    if (hit) begin
      frame = pt_frame_q[cmd_i.page];
    end else if (!full) begin
      frame = frame_t'(filled_q);
    end else begin
      frame = victim;
    end
  end

  assign rsp_o.hit          = hit;
  assign rsp_o.frame        = frame;
  assign rsp_o.owner        = owner;
  assign rsp_o.victim_dirty = !hit && full && dirty_q[owner];

  always_comb begin
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    load_rank_d = load_rank_q;
    use_rank_d  = use_rank_q;
    filled_d    = filled_q;
    if (cmd_i.lookup) begin
      if (hit) begin
        use_rank_d = promote(use_rank_q, frame, use_rank_q[frame],
                             frame_t'(filled_q - 1'b1), filled_q);
      end else begin
        if (!full) begin
          filled_d    = filled_inc;
          load_rank_d = promote(load_rank_q, frame, frame_t'(filled_q),
                                frame_t'(filled_q), filled_inc);
          use_rank_d  = promote(use_rank_q, frame, frame_t'(filled_q),
                                frame_t'(filled_q), filled_inc);
        end else begin
          valid_d[owner] = 1'b0;
          dirty_d[owner] = 1'b0;
          load_rank_d = promote(load_rank_q, frame, load_rank_q[frame],
                                frame_t'(FRAMES - 1), filled_q);
          use_rank_d  = promote(use_rank_q, frame, use_rank_q[frame],
                                frame_t'(FRAMES - 1), filled_q);
        end
        valid_d[cmd_i.page] = 1'b1;
        dirty_d[cmd_i.page] = 1'b0;
      end
    end
    if (cmd_i.set_dirty) begin
      dirty_d[cmd_i.page] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      load_rank_q <= '0;
      use_rank_q  <= '0;
      filled_q    <= '0;
    end else begin
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      load_rank_q <= load_rank_d;
      use_rank_q  <= use_rank_d;
      filled_q    <= filled_d;
    end
  end

  // Mapping fields: read only once written.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && !hit) begin
      owner_q[frame]         <= cmd_i.page;
      pt_frame_q[cmd_i.page] <= frame;
    end
  end

endmodule

// ===== tb/demand_paging_with_replacement_unit_tb.sv =====
module demand_paging_with_replacement_unit_tb;
  import dprw_pkg::*;

  localparam logic OP_READ   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // Slowest run: ~1700 requests, each with its walk through the block, a sender
  // gap and a sink stall; the limit takes that four times over.
  localparam int CYCLE_LIMIT = 750000;

  typedef struct packed {
    logic [WORD_W-1:0] rdata;
    logic              page_fault;
    logic              dirty_evicted;
  } access_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dprw_req_if req_if ();
  dprw_rsp_if rsp_if ();
  dprw_cfg_if cfg_if ();

  demand_paging_with_replacement_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the paging unit: page table, frame ownership, both rank orders
  // and the two memories, updated as each request beat is accepted.
  // ---------------------------------------------------------------------------
  logic      pg_resident [VPAGES];
  logic      pg_dirty    [VPAGES];
  frame_t    pg_frame    [VPAGES];
  page_t     frame_page  [FRAMES];
  rank_vec_t load_order;   // 0 = oldest loaded
  rank_vec_t use_order;    // 0 = least recently used
  int        frames_used;
  dword_t    frame_mem   [FRAMES*PAGE_WORDS];
  dword_t    backing     [VPAGES*PAGE_WORDS];
  logic      lru_mode;

  access_result_t due_replies[$];
  access_result_t want;
  int             errors = 0;
  int             cycles = 0;

  // Stimulus knobs shared by the test tasks
  logic  req_gaps_on;
  logic  rsp_stall_on;
  page_t hot_base;

  function automatic void clear_model();
    for (int p = 0; p < VPAGES; p++) begin
      pg_resident[p] = 1'b0;
      pg_dirty[p]    = 1'b0;
      pg_frame[p]    = '0;
    end
    for (int f = 0; f < FRAMES; f++) begin
      frame_page[f] = '0;
    end
    load_order  = '0;
    use_order   = '0;
    frames_used = 0;
    lru_mode    = MODE_FIFO;
    for (int i = 0; i < FRAMES*PAGE_WORDS; i++) frame_mem[i] = '1;
    for (int i = 0; i < VPAGES*PAGE_WORDS; i++) backing[i] = '1;
  endfunction

  // Lift frame f to rank top; occupied frames ranked above its old place
  // drop by one so the order stays dense.
  function automatic rank_vec_t make_newest(rank_vec_t r, int f, int old, int top);
    rank_vec_t n;
    n = r;
    for (int g = 0; g < FRAMES; g++) begin
      if (g < frames_used && g != f && int'(r[g]) > old) n[g] = r[g] - 1'b1;
    end
    n[f] = frame_t'(top);
    return n;
  endfunction

  // Lowest rank is the victim; ties go to the lower frame number.
  function automatic int lowest_ranked(rank_vec_t r);
    int best;
    best = 0;
    for (int g = 1; g < FRAMES; g++) begin
      if (r[g] < r[best]) best = g;
    end
    return best;
  endfunction

  function automatic access_result_t serve_access(logic is_write, logic [VADDR_W-1:0] va,
                                                  logic [WORD_W-1:0] wd);
    access_result_t res;
    page_t          pg;
    page_t          owner;
    off_t           off;
    int             f;
    pg  = va[VADDR_W-1:OFF_W];
    off = va[OFF_W-1:0];
    res.page_fault    = 1'b0;
    res.dirty_evicted = 1'b0;
    if (pg_resident[pg]) begin
      f = int'(pg_frame[pg]);
      use_order = make_newest(use_order, f, int'(use_order[f]), frames_used - 1);
    end else begin
      res.page_fault = 1'b1;
      if (frames_used < FRAMES) begin
        // free frames are handed out in order
        f = frames_used;
        frames_used++;
        load_order = make_newest(load_order, f, frames_used - 1, frames_used - 1);
        use_order  = make_newest(use_order, f, frames_used - 1, frames_used - 1);
      end else begin
        f     = lowest_ranked(lru_mode ? use_order : load_order);
        owner = frame_page[f];
        if (pg_dirty[owner]) begin
          res.dirty_evicted = 1'b1;
          for (int i = 0; i < PAGE_WORDS; i++)
            backing[owner*PAGE_WORDS + i] = frame_mem[f*PAGE_WORDS + i];
        end
        pg_resident[owner] = 1'b0;
        pg_dirty[owner]    = 1'b0;
        load_order = make_newest(load_order, f, int'(load_order[f]), FRAMES - 1);
        use_order  = make_newest(use_order, f, int'(use_order[f]), FRAMES - 1);
      end
      for (int i = 0; i < PAGE_WORDS; i++)
        frame_mem[f*PAGE_WORDS + i] = backing[pg*PAGE_WORDS + i];
      frame_page[f]   = pg;
      pg_frame[pg]    = frame_t'(f);
      pg_resident[pg] = 1'b1;
      pg_dirty[pg]    = 1'b0;
    end
    if (is_write) begin
      frame_mem[f*PAGE_WORDS + off] = wd;
      pg_dirty[pg] = 1'b1;
      res.rdata    = wd;
    end else begin
      res.rdata = frame_mem[f*PAGE_WORDS + off];
    end
    return res;
  endfunction

  // Config and request beats feed the shadow at the edge they are taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) lru_mode = cfg_if.replacement_mode;
      if (req_if.valid && req_if.ready)
        due_replies.push_back(serve_access(req_if.req_type, req_if.vaddr, req_if.wdata));
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: each reply beat against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic flag_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_replies.size() == 0) begin
        errors++;
        $display("%0t: reply beat with nothing expected, expected none, actual %h",
                 $time, rsp_if.rdata);
      end else begin
        want = due_replies.pop_front();
        flag_field("rdata", want.rdata, rsp_if.rdata);
        flag_field("page_fault", WORD_W'(want.page_fault), WORD_W'(rsp_if.page_fault));
        flag_field("dirty_evicted", WORD_W'(want.dirty_evicted),
                   WORD_W'(rsp_if.dirty_evicted));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Reply sink: ready drops for random stretches while stalling is enabled
  initial begin
    int hold;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (rsp_stall_on && $urandom_range(0, 99) < 30) hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. valid stays high straight into the next beat when no gap is
  // drawn, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_req(logic is_write, logic [VADDR_W-1:0] va, logic [WORD_W-1:0] wd);
    int gap;
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= is_write;
    req_if.vaddr    <= va;
    req_if.wdata    <= wd;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Stop sending and let every outstanding reply come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
  endtask

  // Mode changes only with the unit idle; every request yields a reply, so an
  // empty queue plus a margin is enough.
  task automatic set_mode(logic m);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_if.valid            <= 1'b1;
    cfg_if.replacement_mode <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Random accesses. Most hit a sliding set of FRAMES+1 pages, which keeps a
  // steady mix of hits, clean evictions and dirty copy-backs; wide_pct of
  // them land anywhere in the space.
  task automatic run_random(int n, int wide_pct);
    logic [WORD_W-1:0] wd;
    page_t             pg;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0) hot_base = page_t'($urandom_range(0, VPAGES - 1));
      if ($urandom_range(0, 99) < wide_pct) pg = page_t'($urandom_range(0, VPAGES - 1));
      else pg = hot_base + page_t'($urandom_range(0, FRAMES));
      case ($urandom_range(0, 15))
        0:       wd = '0;
        1:       wd = '1;
        2:       wd = 32'h8000_0000;
        3:       wd = 32'h7fff_ffff;
        default: wd = $urandom;
      endcase
      send_req($urandom_range(0, 1) ? OP_WRITE : OP_READ,
               {pg, off_t'($urandom_range(0, PAGE_WORDS - 1))}, wd);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Cold reads see all-ones, frames fill in order, then FIFO evicts clean and
  // dirty pages; written words must survive the trip through backing memory.
  task automatic test_fill_and_fifo();
    send_req(OP_READ,  7'd0,   $urandom);      // page 0, reset contents
    send_req(OP_WRITE, 7'd127, 32'h7fff_ffff); // page 15, top word
    send_req(OP_WRITE, 7'd8,   32'h8000_0000); // page 1
    send_req(OP_READ,  7'd127, $urandom);      // hit
    send_req(OP_WRITE, 7'd16,  32'h0000_0000); // page 2, last free frame
    send_req(OP_READ,  7'd3,   $urandom);      // hit, no change to load order
    send_req(OP_READ,  7'd24,  $urandom);      // clean victim (page 0)
    send_req(OP_READ,  7'd32,  $urandom);      // dirty victim (page 15)
    send_req(OP_READ,  7'd127, $urandom);      // page 15 back from backing
    send_req(OP_WRITE, 7'd9,   32'hffff_ffff); // page 1 back, page 2 copied out
    send_req(OP_READ,  7'd8,   $urandom);      // hit on reloaded word
  endtask

  // Touch three frames so the fourth is least recent though not oldest.
  task automatic test_lru_victim();
    set_mode(MODE_LRU);
    send_req(OP_READ,  7'd26,  $urandom);
    send_req(OP_WRITE, 7'd33,  32'h1234_5678);
    send_req(OP_READ,  7'd120, $urandom);
    send_req(OP_READ,  7'd48,  $urandom);      // LRU victim is page 1, dirty
    send_req(OP_WRITE, 7'd50,  32'h5555_aaaa); // hit
    send_req(OP_READ,  7'd11,  $urandom);      // page 1 back
    send_req(OP_READ,  7'd0,   $urandom);
    send_req(OP_WRITE, 7'd127, 32'hdead_beef);
  endtask

  // FIFO with idling on both sides; half way the sender holds off until
  // every reply is in.
  task automatic test_random_fifo();
    set_mode(MODE_FIFO);
    run_random(200, 15);
    wait_drained();
    run_random(200, 15);
  endtask

  // LRU at full rate: no sender gaps, sink always ready.
  task automatic test_random_lru_flat_out();
    set_mode(MODE_LRU);
    req_gaps_on  = 1'b0;
    rsp_stall_on = 1'b0;
    run_random(350, 15);
    wait_drained();
    req_gaps_on  = 1'b1;
    rsp_stall_on = 1'b1;
  endtask

  // Flip the mode back and forth over page state left by the earlier run.
  task automatic test_random_mode_flips();
    set_mode(MODE_FIFO);
    run_random(300, 60);
    set_mode(MODE_LRU);
    run_random(300, 60);
    set_mode(MODE_FIFO);
    run_random(300, 5);
  endtask

  initial begin
    clear_model();
    req_gaps_on  = 1'b1;
    rsp_stall_on = 1'b1;
    hot_base     = '0;
    rst_ni                  <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.req_type         <= OP_READ;
    req_if.vaddr            <= '0;
    req_if.wdata            <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.replacement_mode <= MODE_FIFO;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_fifo();
    test_lru_victim();
    test_random_fifo();
    test_random_lru_flat_out();
    test_random_mode_flips();

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
